>>> src/sam_pkg.sv
`timescale 1ns / 1ps

package sam_pkg;

    localparam int DATA_W      = 32;
    localparam int FRAC_BITS   = 16;
    localparam int STACK_DEPTH = 256;
    localparam int CONST_DEPTH = 256;
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int STACK_AW    = $clog2(STACK_DEPTH);
    localparam int CONST_AW    = $clog2(CONST_DEPTH);
    localparam int OP_W        = 8;
    localparam int IDX_W       = 8;
    localparam int REQ_W       = 2;
    localparam int STAT_W      = 2;

    // long-division width: dividend is |a| << FRAC_BITS plus half the divisor
    localparam int DIV_W       = DATA_W + FRAC_BITS;
    localparam int CNT_W       = $clog2(DIV_W);
    localparam int PROD_W      = 2 * DATA_W;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_FIELD_W = STAT_W + DATA_W + SP_W;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

    localparam logic signed [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [DIV_W-1:0] MAG_MAX = {{(DIV_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
    localparam logic [DIV_W-1:0] MAG_MIN =
        {{(DIV_W-DATA_W){1'b0}}, 1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [PROD_W-1:0] HALF_LSB = PROD_W'(1) << (FRAC_BITS - 1);

    localparam logic [OP_W-1:0] OP_PUSH_CONST = 8'd0;
    localparam logic [OP_W-1:0] OP_ADD        = 8'd1;
    localparam logic [OP_W-1:0] OP_SUB        = 8'd2;
    localparam logic [OP_W-1:0] OP_MUL        = 8'd3;
    localparam logic [OP_W-1:0] OP_DIV        = 8'd4;
    localparam logic [OP_W-1:0] OP_NEG        = 8'd5;
    localparam logic [OP_W-1:0] OP_RETURN     = 8'd6;

    typedef enum logic [REQ_W-1:0] {
        REQ_EXEC      = 2'd0,
        REQ_CONST_WR  = 2'd1,
        REQ_STACK_CLR = 2'd2,
        REQ_NOP       = 2'd3
    } t_req;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_UNDERFLOW = 2'd1,
        STAT_OVERFLOW  = 2'd2,
        STAT_DIV_ZERO  = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_DOWN,
        CELL_UP
    } t_cell_op;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_top_st;

    typedef enum logic [1:0] {
        ALU_IDLE,
        ALU_MUL,
        ALU_DIV
    } t_alu_st;

    typedef struct packed {
        logic start;
        logic is_div;
    } t_alu_req;

    typedef struct packed {
        logic                     done;
        logic signed [DATA_W-1:0] result;
    } t_alu_rsp;

    // saturate a sign/magnitude pair to the value range
    function automatic logic signed [DATA_W-1:0] f_sat_mag(input logic [DIV_W-1:0] mag,
                                                            input logic neg);
        logic [DATA_W-1:0] low;
        low = mag[DATA_W-1:0];
        if (neg) begin
            if (mag > MAG_MIN) return Q_MIN;
            return -low;
        end
        if (mag > MAG_MAX) return Q_MAX;
        return low;
    endfunction

    // saturate a sum that grew by one bit
    function automatic logic signed [DATA_W-1:0] f_sat_wide(input logic signed [DATA_W:0] v);
        if (v[DATA_W] != v[DATA_W-1]) return v[DATA_W] ? Q_MIN : Q_MAX;
        return v[DATA_W-1:0];
    endfunction

endpackage

>>> src/stack_arithmetic_vm.sv
`timescale 1ns / 1ps
// channel  | dir | beat contents
// s_*      | in  | tuser: req_type; tdata: opcode, const_index, const_value
// m_*      | out | tuser: returned; tdata: status, result_value, stack_depth
//
// One item at a time. Constant pushes, ADD, SUB, NEG, RETURN, table writes and stack
// clears go through accept, then commit (the constant RAM read is registered).
// MUL adds a product register, then round and saturate, before the commit.
// DIV runs all 48 quotient bits through the bit-serial divider between accept and commit.
// The stack is a row of cells, top at cell 0, shifted as a whole on push and pop.
// Synchronous active-low reset empties the stack; table contents survive it.
// A stalled result sits in the output register while the core works on the next item, whose commit waits.

module stack_arithmetic_vm import sam_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // opcode[7:0], const_index[15:8], const_value[47:16]
    input  logic [REQ_W-1:0]       s_tuser,   // req_type[1:0]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // status[1:0], result_value[33:2],
                                              // stack_depth[42:34], zero[47:43]
    output logic                   m_tuser    // returned[0]
);

    t_top_st r_state, n_state;
    logic [SP_W-1:0] r_sp, n_sp;
    t_req            r_req;
    logic [OP_W-1:0] r_op;
    logic [IDX_W-1:0] r_idx;
    logic            r_need_alu;

    logic                   r_m_valid;
    logic [OUT_TDATA_W-1:0] r_m_tdata;
    logic                   r_m_tuser;

    logic signed [DATA_W-1:0] w_cell [STACK_DEPTH];
    logic signed [DATA_W-1:0] w_top, w_second;
    logic signed [DATA_W-1:0] w_new_top, w_top_after, w_bin, w_neg, w_result;
    logic signed [DATA_W-1:0] w_ram_rdata;
    t_cell_op                 w_cmd0, w_cmdn;
    t_status                  w_status;
    logic                     w_returned;

    logic            w_accept, w_commit, w_start;
    logic [OP_W-1:0] w_in_op;
    logic [IDX_W-1:0] w_in_idx;
    logic [IDX_W-1:0] w_ram_idx;
    t_alu_req        w_alu_req;
    t_alu_rsp        w_alu_rsp;

    assign w_in_op  = s_tdata[OP_W-1:0];
    assign w_in_idx = s_tdata[OP_W +: IDX_W];
    assign w_top    = w_cell[0];
    assign w_second = w_cell[1];

    assign s_tready = (r_state == ST_IDLE);
    assign w_accept = s_tvalid && s_tready;

    // keep reading the accepted entry while the commit waits on the output
    assign w_ram_idx = (r_state == ST_IDLE) ? w_in_idx : r_idx;

    assign w_start = w_accept && (t_req'(s_tuser) == REQ_EXEC) && (r_sp >= SP_W'(2))
                     && ((w_in_op == OP_MUL) || ((w_in_op == OP_DIV) && (w_top != '0)));
    assign w_alu_req.start  = w_start;
    assign w_alu_req.is_div = (w_in_op == OP_DIV);

    assign w_commit = (r_state == ST_RUN) && (!r_need_alu || w_alu_rsp.done)
                      && (!r_m_valid || m_tready);

    sam_ram #(
        .WIDTH (DATA_W),
        .DEPTH (CONST_DEPTH)
    ) u_const_ram (
        .i_clk   (i_clk),
        .i_we    (w_accept && (t_req'(s_tuser) == REQ_CONST_WR)),
        .i_addr  (CONST_AW'(w_ram_idx)),
        .i_wdata (s_tdata[OP_W+IDX_W +: DATA_W]),
        .o_rdata (w_ram_rdata)
    );

    sam_alu u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_alu_req),
        .i_a     (w_second),
        .i_b     (w_top),
        .o_rsp   (w_alu_rsp)
    );

    genvar g;
    generate
        for (g = 0; g < STACK_DEPTH; g++) begin : g_cell
            if (g == 0) begin : g_head
                sam_cell u_cell (
                    .i_clk   (i_clk),
                    .i_cmd   (w_cmd0),
                    .i_prev  (w_new_top),
                    .i_next  (w_cell[1]),
                    .o_value (w_cell[0])
                );
            end else if (g == STACK_DEPTH - 1) begin : g_tail
                sam_cell u_cell (
                    .i_clk   (i_clk),
                    .i_cmd   (w_cmdn),
                    .i_prev  (w_cell[g-1]),
                    .i_next  ('0),
                    .o_value (w_cell[g])
                );
            end else begin : g_mid
                sam_cell u_cell (
                    .i_clk   (i_clk),
                    .i_cmd   (w_cmdn),
                    .i_prev  (w_cell[g-1]),
                    .i_next  (w_cell[g+1]),
                    .o_value (w_cell[g])
                );
            end
        end
    endgenerate

    // binary op result; left operand sits below the top
    always_comb begin
        w_neg = (w_top == Q_MIN) ? Q_MAX : -w_top;
        case (r_op)
            OP_ADD:  w_bin = f_sat_wide({w_second[DATA_W-1], w_second} + {w_top[DATA_W-1], w_top});
            OP_SUB:  w_bin = f_sat_wide({w_second[DATA_W-1], w_second} - {w_top[DATA_W-1], w_top});
            OP_DIV: begin
                if (w_top != '0) begin
                    w_bin = w_alu_rsp.result;
                end else if (w_second[DATA_W-1]) begin
                    w_bin = Q_MIN;
                end else if (w_second != '0) begin
                    w_bin = Q_MAX;
                end else begin
                    w_bin = '0;
                end
            end
            default: w_bin = w_alu_rsp.result;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_sp      <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_sp    <= n_sp;
            if (w_commit) begin
                r_m_valid <= 1'b1;
            end else if (m_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req      <= t_req'(s_tuser);
            r_op       <= w_in_op;
            r_idx      <= w_in_idx;
            r_need_alu <= w_start;
        end
        if (w_commit) begin
            r_m_tdata <= {{OUT_PAD_W{1'b0}}, n_sp, w_result, w_status};
            r_m_tuser <= w_returned;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_sp        = r_sp;
        w_cmd0      = CELL_HOLD;
        w_cmdn      = CELL_HOLD;
        w_new_top   = w_top;
        w_top_after = w_top;
        w_status    = STAT_OK;
        w_returned  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) n_state = ST_RUN;
            end
            ST_RUN: begin
                if (w_commit) begin
                    n_state = ST_IDLE;
                    case (r_req)
                        REQ_STACK_CLR: n_sp = '0;
                        REQ_EXEC: begin
                            case (r_op)
                                OP_PUSH_CONST: begin
                                    if (r_sp == SP_W'(STACK_DEPTH)) begin
                                        w_status = STAT_OVERFLOW;
                                    end else begin
                                        w_new_top   = w_ram_rdata;
                                        w_top_after = w_ram_rdata;
                                        w_cmd0      = CELL_DOWN;
                                        w_cmdn      = CELL_DOWN;
                                        n_sp        = r_sp + 1'b1;
                                    end
                                end
                                OP_ADD, OP_SUB, OP_MUL, OP_DIV: begin
                                    if (r_sp < SP_W'(2)) begin
                                        w_status = STAT_UNDERFLOW;
                                    end else begin
                                        w_new_top   = w_bin;
                                        w_top_after = w_bin;
                                        w_cmd0      = CELL_DOWN;
                                        w_cmdn      = CELL_UP;
                                        n_sp        = r_sp - 1'b1;
                                        if (r_op == OP_DIV && w_top == '0) begin
                                            w_status = STAT_DIV_ZERO;
                                        end
                                    end
                                end
                                OP_NEG: begin
                                    if (r_sp == '0) begin
                                        w_status = STAT_UNDERFLOW;
                                    end else begin
                                        w_new_top   = w_neg;
                                        w_top_after = w_neg;
                                        w_cmd0      = CELL_DOWN;
                                    end
                                end
                                OP_RETURN: begin
                                    if (r_sp == '0) begin
                                        w_status = STAT_UNDERFLOW;
                                    end else begin
                                        w_cmd0     = CELL_UP;
                                        w_cmdn     = CELL_UP;
                                        n_sp       = r_sp - 1'b1;
                                        w_returned = 1'b1;
                                    end
                                end
                                default: ;
                            endcase
                        end
                        default: ;
                    endcase
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign w_result = (!w_returned && n_sp == '0) ? '0 : w_top_after;

    assign m_tvalid = r_m_valid;
    assign m_tdata  = r_m_tdata;
    assign m_tuser  = r_m_tuser;

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sp <= SP_W'(STACK_DEPTH))
        else $error("stack pointer beyond stack depth");

    a_idle_holds_sp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |=> $stable(r_sp))
        else $error("stack pointer moved without a commit");

    a_return_pops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_commit && w_returned) |=> (r_sp == $past(r_sp) - SP_W'(1)))
        else $error("return did not pop one entry");

    a_alu_before_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && r_need_alu && !w_alu_rsp.done) |=> (r_state == ST_RUN))
        else $error("commit left before arithmetic unit finished");

endmodule

>>> src/sam_ram.sv
`timescale 1ns / 1ps

module sam_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/sam_cell.sv
`timescale 1ns / 1ps

module sam_cell import sam_pkg::*; (
    input  logic                     i_clk,
    input  t_cell_op                 i_cmd,
    input  logic signed [DATA_W-1:0] i_prev,
    input  logic signed [DATA_W-1:0] i_next,
    output logic signed [DATA_W-1:0] o_value
);

    logic signed [DATA_W-1:0] r_value;

    // down: take the entry nearer the top (push); up: take the one below (pop)
    always_ff @(posedge i_clk) begin
        case (i_cmd)
            CELL_DOWN: r_value <= i_prev;
            CELL_UP:   r_value <= i_next;
            default:   r_value <= r_value;
        endcase
    end

    assign o_value = r_value;

endmodule

>>> src/sam_alu.sv
`timescale 1ns / 1ps

module sam_alu import sam_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_alu_req                 i_req,
    input  logic signed [DATA_W-1:0] i_a,
    input  logic signed [DATA_W-1:0] i_b,
    output t_alu_rsp                 o_rsp
);

    t_alu_st r_state, n_state;
    logic    r_done, n_done;

    logic                     r_neg;
    logic [PROD_W-1:0]        r_prod;
    logic [DIV_W-1:0]         r_num;
    logic [DATA_W-1:0]        r_den;
    logic [DATA_W-1:0]        r_rem;
    logic [CNT_W-1:0]         r_cnt;
    logic signed [DATA_W-1:0] r_result;

    logic [DATA_W-1:0] w_mag_a, w_mag_b;
    logic [DIV_W-1:0]  w_dividend;
    logic [PROD_W-1:0] w_prod_rnd;
    logic [DATA_W:0]   w_rem_sh;
    logic              w_ge;
    logic [DATA_W:0]   w_rem_sub;

    assign w_mag_a    = i_a[DATA_W-1] ? (~i_a) + 1'b1 : i_a;
    assign w_mag_b    = i_b[DATA_W-1] ? (~i_b) + 1'b1 : i_b;
    assign w_dividend = {w_mag_a, {FRAC_BITS{1'b0}}} + DIV_W'(w_mag_b >> 1);
    assign w_prod_rnd = r_prod + HALF_LSB;

    // restoring division, one quotient bit per cycle; r_num shifts into the quotient
    assign w_rem_sh  = {r_rem, r_num[DIV_W-1]};
    assign w_ge      = (w_rem_sh >= {1'b0, r_den});
    assign w_rem_sub = w_rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ALU_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_comb begin
        n_state = r_state;
        n_done  = r_done;
        case (r_state)
            ALU_IDLE: begin
                if (i_req.start) begin
                    n_done  = 1'b0;
                    n_state = i_req.is_div ? ALU_DIV : ALU_MUL;
                end
            end
            ALU_MUL: begin
                n_done  = 1'b1;
                n_state = ALU_IDLE;
            end
            ALU_DIV: begin
                if (r_cnt == '0) begin
                    n_done  = 1'b1;
                    n_state = ALU_IDLE;
                end
            end
            default: n_state = ALU_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ALU_IDLE && i_req.start) begin
            r_neg  <= i_a[DATA_W-1] ^ i_b[DATA_W-1];
            r_prod <= w_mag_a * w_mag_b;
            r_num  <= w_dividend;
            r_den  <= w_mag_b;
            r_rem  <= '0;
            r_cnt  <= CNT_W'(DIV_W - 1);
        end else if (r_state == ALU_MUL) begin
            r_result <= f_sat_mag(w_prod_rnd[FRAC_BITS +: DIV_W], r_neg);
        end else if (r_state == ALU_DIV) begin
            r_rem <= w_ge ? w_rem_sub[DATA_W-1:0] : w_rem_sh[DATA_W-1:0];
            r_num <= {r_num[DIV_W-2:0], w_ge};
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == '0) begin
                r_result <= f_sat_mag({r_num[DIV_W-2:0], w_ge}, r_neg);
            end
        end
    end

    assign o_rsp.done   = r_done;
    assign o_rsp.result = r_result;

endmodule
